// ===== rtl/core/r2y_pkg.sv =====
// ----------------------------------------------------------------------------
// r2y_pkg
// Types, coefficients and helpers for the RGB555 to YUY2 packer.
// ----------------------------------------------------------------------------
package r2y_pkg;

   typedef struct packed {
      logic [7:0] y;
      logic [7:0] u;
      logic [7:0] v;
   } yuv_type;

   // register index, taken from the word address of the config port
   localparam logic REG_DOUBLE_WIDTH = 1'b0;
   localparam logic REG_MSB_FIRST    = 1'b1;

   localparam int  PADDR_WIDTH = 3;
   localparam int  PDATA_WIDTH = 32;

   // BT.601-style coefficients, Q15
   localparam logic signed [24:0] Y_R   =  25'sd8453;
   localparam logic signed [24:0] Y_G   =  25'sd16594;
   localparam logic signed [24:0] Y_B   =  25'sd3223;
   localparam logic signed [24:0] Y_OFS =  25'sd524288;
   localparam logic signed [24:0] U_R   = -25'sd4878;
   localparam logic signed [24:0] U_G   = -25'sd9578;
   localparam logic signed [24:0] U_B   =  25'sd14456;
   localparam logic signed [24:0] C_OFS =  25'sd4210688;
   localparam logic signed [24:0] V_R   =  25'sd14456;
   localparam logic signed [24:0] V_G   = -25'sd12105;
   localparam logic signed [24:0] V_B   = -25'sd2351;

   // 5-bit channel to 8 bits by replicating the top bits
   function automatic logic signed [24:0] widen5(input logic [4:0] c);
      return $signed({17'b0, c, c[4:2]});
   endfunction

   function automatic yuv_type pixel_yuv(input logic [14:0] pix);
      logic signed [24:0] r;
      logic signed [24:0] g;
      logic signed [24:0] b;
      logic signed [24:0] y_sum;
      logic signed [24:0] u_sum;
      logic signed [24:0] v_sum;
      yuv_type            res;
      r = widen5(pix[14:10]);
      g = widen5(pix[9:5]);
      b = widen5(pix[4:0]);
      // all sums stay in 0 .. 2^23-1, so bits 22:15 are the result
      y_sum = Y_R * r + Y_G * g + Y_B * b + Y_OFS;
      u_sum = U_R * r + U_G * g + U_B * b + C_OFS;
      v_sum = V_R * r + V_G * g + V_B * b + C_OFS;
      res.y = y_sum[22:15];
      res.u = u_sum[22:15];
      res.v = v_sum[22:15];
      return res;
   endfunction

   function automatic logic [31:0] pack_word(input logic [7:0] y_a, input logic [7:0] u,
                                             input logic [7:0] y_b, input logic [7:0] v,
                                             input logic msb_first);
      if (msb_first) begin
         return {y_a, u, y_b, v};
      end
      return {v, y_b, u, y_a};
   endfunction

endpackage

// ===== rtl/core/rgb555_to_yuy2_packer.sv =====
// ----------------------------------------------------------------------------
// rgb555_to_yuy2_packer
// Converts a pair of RGB555 pixels into packed YUY2 words.
// ----------------------------------------------------------------------------
// A pixel pair is registered on entry, converted by constant multiplies in
// one combinational pass and placed in the result register once it is free.
// In normal mode one packed word with averaged chroma leaves per pair and a
// new pair is taken every cycle while the result side does not stall. In
// double-width mode each pair gives two words, one per pixel, through the
// single result register, holding the pair until both are loaded; the second
// word follows the first in the next cycle unless the result side stalls.
// Configuration registers: 0x0 double_width, 0x4 msb_first_order (bit 0).
module rgb555_to_yuy2_packer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [14:0]                        req_pixel_first,
   input  logic [14:0]                        req_pixel_second,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [31:0]                        rsp_packed_word,
   output logic                               rsp_last_of_item,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [r2y_pkg::PADDR_WIDTH-1:0]    paddr,
   input  logic [r2y_pkg::PDATA_WIDTH-1:0]    pwdata,
   output logic [r2y_pkg::PDATA_WIDTH-1:0]    prdata,
   output logic                               pready
);

   logic double_width_ff;
   logic msb_first_ff;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [14:0] pix_a_ff;
   logic [14:0] pix_b_ff;
   logic        phase_ff;
   logic        phase_in;

   logic        out_valid_ff;
   logic        out_valid_in;
   logic [31:0] word_ff;
   logic [31:0] word_in;
   logic        last_ff;
   logic        last_in;

   logic             out_free;
   logic             out_load;
   logic             in_consume;
   logic             in_load;
   logic             csr_write;
   r2y_pkg::yuv_type yuv_a;
   r2y_pkg::yuv_type yuv_b;
   logic [8:0]       u_sum;
   logic [8:0]       v_sum;
   logic [7:0]       u_avg;
   logic [7:0]       v_avg;

   // configuration port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         double_width_ff <= 1'b0;
         msb_first_ff    <= 1'b0;
      end else if (csr_write) begin
         if (paddr[2] == r2y_pkg::REG_DOUBLE_WIDTH) begin
            double_width_ff <= pwdata[0];
         end
         if (paddr[2] == r2y_pkg::REG_MSB_FIRST) begin
            msb_first_ff <= pwdata[0];
         end
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == r2y_pkg::REG_DOUBLE_WIDTH) begin
         prdata[0] = double_width_ff;
      end else begin
         prdata[0] = msb_first_ff;
      end
   end

   // conversion
   assign yuv_a = r2y_pkg::pixel_yuv(pix_a_ff);
   assign yuv_b = r2y_pkg::pixel_yuv(pix_b_ff);
   assign u_sum = {1'b0, yuv_a.u} + {1'b0, yuv_b.u};
   assign v_sum = {1'b0, yuv_a.v} + {1'b0, yuv_b.v};
   assign u_avg = u_sum[8:1];
   // in msb-first order the V lane drops each pixel's low bit before adding
   assign v_avg = msb_first_ff ? ({1'b0, yuv_a.v[7:1]} + {1'b0, yuv_b.v[7:1]})
                               : v_sum[8:1];

   // handshake
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign out_load   = in_valid_ff && out_free;
   assign in_consume = out_load && (!double_width_ff || phase_ff);
   assign in_load    = !in_valid_ff || in_consume;
   assign req_stall  = !in_load;

   always_comb begin
      in_valid_in  = in_valid_ff;
      phase_in     = phase_ff;
      out_valid_in = out_valid_ff;
      word_in      = word_ff;
      last_in      = last_ff;
      if (in_load) begin
         in_valid_in = req_valid;
      end
      if (out_load) begin
         out_valid_in = 1'b1;
         if (double_width_ff && !phase_ff) begin
            word_in  = r2y_pkg::pack_word(yuv_a.y, yuv_a.u, yuv_a.y, yuv_a.v, msb_first_ff);
            last_in  = 1'b0;
            phase_in = 1'b1;
         end else if (double_width_ff) begin
            word_in  = r2y_pkg::pack_word(yuv_b.y, yuv_b.u, yuv_b.y, yuv_b.v, msb_first_ff);
            last_in  = 1'b1;
            phase_in = 1'b0;
         end else begin
            word_in  = r2y_pkg::pack_word(yuv_a.y, u_avg, yuv_b.y, v_avg, msb_first_ff);
            last_in  = 1'b1;
            phase_in = 1'b0;
         end
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         pix_a_ff <= req_pixel_first;
         pix_b_ff <= req_pixel_second;
      end
      word_ff <= word_in;
      last_ff <= last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_packed_word  = word_ff;
   assign rsp_last_of_item = last_ff;

   // the input side only holds off while a pair is waiting in the input register
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("input stalled with empty input register");

   // a pending second word implies its pair is still held
   a_phase_holds_item: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> in_valid_ff)
      else $error("second word pending without a held pair");

   // a non-final word is always followed by the rest of its pair
   a_first_word_pending: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !last_ff) |-> phase_ff)
      else $error("first word shown without its second word pending");

   // once the first word of a pair is taken the second is shown next cycle
   a_second_word_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_last_of_item) |=> (rsp_valid && rsp_last_of_item))
      else $error("second word did not follow the first");

endmodule

// ===== tb/rgb555_to_yuy2_packer_tb.sv =====
// ----------------------------------------------------------------------------
// rgb555_to_yuy2_packer_tb
// Self-checking bench for the RGB555 pair to YUY2 packer. Pixel pairs come
// from a queue and go through a valid/stall driver with random gaps. Each
// accepted pair is turned into its expected words at the accepting edge.
// A monitor with random back-pressure compares every word and its
// last-of-pair flag. Both modes and both byte orders are run, with the
// settings written over the register port between phases.
// ----------------------------------------------------------------------------
module rgb555_to_yuy2_packer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [14:0] first;
      logic [14:0] second;
   } pixel_pair_type;

   typedef struct {
      logic [31:0] word;
      logic        last;
   } yuy2_word_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [14:0]                     req_pixel_first = '0;
   logic [14:0]                     req_pixel_second = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [31:0]                     rsp_packed_word;
   logic                            rsp_last_of_item;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [r2y_pkg::PADDR_WIDTH-1:0] paddr = '0;
   logic [r2y_pkg::PDATA_WIDTH-1:0] pwdata = '0;
   logic [r2y_pkg::PDATA_WIDTH-1:0] prdata;
   logic                            pready;

   // settings as the block should hold them
   logic cfg_double_width = 1'b0;
   logic cfg_msb_first    = 1'b0;

   pixel_pair_type pair_queue[$];
   yuy2_word_type  yuy2_expected[$];

   bit idle_on = 1'b1;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int send_gap = 0;
   int recv_gap = 0;
   int err_count = 0;

   rgb555_to_yuy2_packer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel_first  (req_pixel_first),
      .req_pixel_second (req_pixel_second),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_packed_word  (rsp_packed_word),
      .rsp_last_of_item (rsp_last_of_item),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("FAILURE");
      $finish;
   end

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      err_count++;
   endtask

   // Y U Y V word of one pixel, channels widened by replicating top bits
   function automatic logic [31:0] pixel_yuy2(input logic [14:0] pix, input logic msb);
      int         r;
      int         g;
      int         b;
      int         y;
      int         u;
      int         v;
      logic [7:0] yb;
      logic [7:0] ub;
      logic [7:0] vb;
      r = int'({pix[14:10], pix[14:12]});
      g = int'({pix[9:5], pix[9:7]});
      b = int'({pix[4:0], pix[4:2]});
      y = (8453 * r + 16594 * g + 3223 * b + 524288) >>> 15;
      u = (-4878 * r - 9578 * g + 14456 * b + 4210688) >>> 15;
      v = (14456 * r - 12105 * g - 2351 * b + 4210688) >>> 15;
      yb = y[7:0];
      ub = u[7:0];
      vb = v[7:0];
      return msb ? {yb, ub, yb, vb} : {vb, yb, ub, yb};
   endfunction

   task automatic predict_words(input logic [14:0] pa, input logic [14:0] pb);
      logic [31:0] w1;
      logic [31:0] w2;
      logic [31:0] y1mask;
      logic [31:0] y2mask;
      logic [31:0] uvmask;
      logic [31:0] uv;
      w1 = pixel_yuy2(pa, cfg_msb_first);
      w2 = pixel_yuy2(pb, cfg_msb_first);
      if (cfg_double_width) begin
         yuy2_expected.push_back('{word: w1, last: 1'b0});
         yuy2_expected.push_back('{word: w2, last: 1'b1});
      end else begin
         if (cfg_msb_first) begin
            y1mask = 32'hFF00_0000;
            y2mask = 32'h0000_FF00;
            uvmask = 32'h00FF_00FF;
         end else begin
            y1mask = 32'h0000_00FF;
            y2mask = 32'h00FF_0000;
            uvmask = 32'hFF00_FF00;
         end
         // half of each chroma lane, summed; low bit of a lane may spill below
         uv = ((w1 & uvmask) >> 1) + ((w2 & uvmask) >> 1);
         yuy2_expected.push_back('{word: (w1 & y1mask) | (w2 & y2mask) | (uv & uvmask),
                                   last: 1'b1});
      end
   endtask

   // driver: holds a stalled transaction, otherwise gaps or next pair
   always @(posedge clock) begin
      pixel_pair_type np;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_words(req_pixel_first, req_pixel_second);
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(7) == 0) begin
               send_gap = $urandom_range(14, 1) - 1;
               req_valid <= 1'b0;
            end else if (pair_queue.size() > 0) begin
               np = pair_queue.pop_front();
               req_valid <= 1'b1;
               req_pixel_first <= np.first;
               req_pixel_second <= np.second;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted word, drives back-pressure
   always @(posedge clock) begin
      yuy2_word_type exp_w;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (yuy2_expected.size() == 0) begin
               report($sformatf("unexpected word %h last %b", rsp_packed_word,
                                rsp_last_of_item));
            end else begin
               exp_w = yuy2_expected.pop_front();
               if (rsp_packed_word !== exp_w.word)
                  report($sformatf("packed_word %h, expected %h", rsp_packed_word,
                                   exp_w.word));
               if (rsp_last_of_item !== exp_w.last)
                  report($sformatf("last_of_item %b, expected %b", rsp_last_of_item,
                                   exp_w.last));
            end
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(7) == 0) begin
            recv_gap = $urandom_range(14, 1) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_write(input logic idx, input logic [r2y_pkg::PDATA_WIDTH-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // upper data bits are random, only bit 0 should matter
   task automatic configure(input logic dbl, input logic msb);
      logic [r2y_pkg::PDATA_WIDTH-1:0] val;
      val = $urandom();
      val[0] = dbl;
      csr_write(r2y_pkg::REG_DOUBLE_WIDTH, val);
      val = $urandom();
      val[0] = msb;
      csr_write(r2y_pkg::REG_MSB_FIRST, val);
      cfg_double_width = dbl;
      cfg_msb_first = msb;
   endtask

   task automatic drain();
      @(negedge clock);
      while (pair_queue.size() > 0 || req_valid) @(negedge clock);
      while (yuy2_expected.size() > 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // mostly uniform, some with every channel at zero or full scale
   function automatic logic [14:0] rand_pixel();
      logic [14:0] p;
      if ($urandom_range(3) == 0) begin
         p[14:10] = $urandom_range(1) ? 5'd31 : 5'd0;
         p[9:5] = $urandom_range(1) ? 5'd31 : 5'd0;
         p[4:0] = $urandom_range(1) ? 5'd31 : 5'd0;
      end else begin
         p = 15'($urandom_range(32767));
      end
      return p;
   endfunction

   initial begin
      logic [14:0] dir_a[6];
      logic [14:0] dir_b[6];
      int          m;
      int          ph;
      int          i;
      dir_a = '{15'h0000, 15'h7FFF, 15'h7C00, 15'h001F, 15'h7C1F, 15'h0421};
      dir_b = '{15'h0000, 15'h7FFF, 15'h03E0, 15'h7FFF, 15'h03E0, 15'h7BDE};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // extremes and odd chroma sums in every mode and byte order
      for (m = 0; m < 4; m++) begin
         configure(m[0], m[1]);
         for (i = 0; i < 6; i++) pair_queue.push_back('{first: dir_a[i], second: dir_b[i]});
         drain();
      end

      for (ph = 0; ph < 8; ph++) begin
         idle_on = (ph != 3 && ph != 7);
         if (ph < 4) configure(ph[0], ph[1]);
         else configure(1'($urandom_range(1)), 1'($urandom_range(1)));
         for (i = 0; i < 128; i++)
            pair_queue.push_back('{first: rand_pixel(), second: rand_pixel()});
         // long receiver hold while the sender keeps offering
         if (ph == 2 || ph == 5) hold_requests++;
         drain();
      end

      if (err_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
